// ===== design/smj_pkg.sv =====
// Shared widths, types and command codes of the sort-merge ID join.
package smj_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ID_W        = 64;

  typedef logic signed [ID_W-1:0]  id_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic signed [CNT_W-1:0] mat_t;

  localparam cnt_t CNT_MAX  = CNT_W'(MAX_ENTRIES);
  localparam mat_t NO_MATCH = '1;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_LOAD_A = 2'd1;
  localparam logic [1:0] CMD_LOAD_B = 2'd2;
  localparam logic [1:0] CMD_FETCH  = 2'd3;

  localparam logic [1:0] PH_LOAD = 2'd0;
  localparam logic [1:0] PH_EMIT = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

endpackage

// ===== design/smj_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
module smj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sort_merge_id_join.sv =====
// Top level of the sort-merge ID join: sequencer and list memories.
//
// Usage: start with in_command; an item is taken when start is high and busy low.
// Clear and load items never raise busy, so loads can stream at one per cycle;
// a load into a full list is dropped and sets a flag, shown on out_overflowed with each result, until a clear.
// A fetch item always returns exactly one result, marked by a one-cycle out_valid
// strobe; a fetch that has work to do raises busy, and busy falls in the cycle the
// result appears. A fetch after the join has ended answers in the next cycle.
// The first fetch after loading (or after a join_mode write) sorts both lists by
// a rank sweep that reads the whole list once per entry through the single read
// port of the ID memory. Inner mode then merges the sorted lists, each merge step
// a check state and a compare state; each fetch runs ahead to the next pair so
// that out_last_result is known. Outer mode first builds both first-match tables
// in one merge pass per list, then each fetch reads one table entry and emits it.
// Later inner fetches step past the held pair (ST_ADV, ST_ADV_CHK, ST_ADV_CMP),
// then merge until the next pair.
// The receiver cannot stall: every result is valid for exactly one cycle.
// Reset (rst_n low, synchronous) empties both lists, clears the overflow flag
// and selects inner mode; memory contents are not cleared.
// cfg_wr_en/cfg_wr_data write join_mode and must only be used while idle.
module sort_merge_id_join import smj_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_command,
  input  logic signed [63:0] in_id_value,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  output logic             out_valid,
  output logic             out_side,
  output logic [9:0]       out_first_index,
  output logic signed [10:0] out_second_index,
  output logic             out_last_result,
  output logic             out_nothing_left,
  output logic             out_overflowed
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SRT_NEXT = 4'd1;
  localparam logic [3:0] ST_SRT_KEY  = 4'd2;
  localparam logic [3:0] ST_SRT_KEYW = 4'd3;
  localparam logic [3:0] ST_SRT_SWP  = 4'd4;
  localparam logic [3:0] ST_SRT_WR   = 4'd5;
  localparam logic [3:0] ST_FM_CHK   = 4'd6;
  localparam logic [3:0] ST_FM_CMP   = 4'd7;
  localparam logic [3:0] ST_O_RD     = 4'd8;
  localparam logic [3:0] ST_O_EMIT   = 4'd9;
  localparam logic [3:0] ST_SEEK     = 4'd10;
  localparam logic [3:0] ST_SEEK_CMP = 4'd11;
  localparam logic [3:0] ST_ADV      = 4'd12;
  localparam logic [3:0] ST_ADV_CHK  = 4'd13;
  localparam logic [3:0] ST_ADV_CMP  = 4'd14;

  logic [3:0] st_r, st_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       mode_r, mode_nxt;
  logic       drop_r, drop_nxt;
  cnt_t       cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic       srt_sel_r, srt_sel_nxt;
  cnt_t       k_r, k_nxt, j_r, j_nxt;
  logic       cmp_vld_r, cmp_vld_nxt;
  idx_t       cmp_idx_r, cmp_idx_nxt;
  idx_t       rank_r, rank_nxt;
  id_t        key_r, key_nxt;
  cnt_t       pa_r, pa_nxt, pb_r, pb_nxt, sc_r, sc_nxt;
  logic       fm_sel_r, fm_sel_nxt;
  logic       have_cur_r, have_cur_nxt;
  idx_t       cur_f_r, cur_f_nxt, cur_s_r, cur_s_nxt;
  cnt_t       oc_r, oc_nxt;
  logic       osd_r, osd_nxt;

  logic       ov_r, ov_nxt;
  logic       os_r, os_nxt;
  idx_t       of_r, of_nxt;
  mat_t       osec_r, osec_nxt;
  logic       ol_r, ol_nxt;
  logic       on_r, on_nxt;
  logic       oo_r, oo_nxt;

  // memory ports
  logic ids_a_we, ids_b_we, srt_a_we, srt_b_we, ma_we, mb_we;
  idx_t ids_raddr, a_raddr, b_raddr, m_raddr, ma_waddr, mb_waddr;
  mat_t m_wdata;
  id_t  ids_a_rd, ids_b_rd, sa_rd, sb_rd;
  idx_t oa_rd, ob_rd;
  mat_t ma_rd, mb_rd;

  // merge results
  logic fnd, nfnd;
  idx_t fnd_f, fnd_s;
  id_t  key_rd;
  cnt_t srt_n, fm_i, fm_n1;
  logic a_lt_b, a_gt_b;

  assign ids_raddr = (st_r == ST_SRT_KEY) ? k_r[IDX_W-1:0] : j_r[IDX_W-1:0];
  assign a_raddr   = pa_r[IDX_W-1:0];
  assign b_raddr   = (st_r == ST_ADV_CHK) ? sc_r[IDX_W-1:0] : pb_r[IDX_W-1:0];
  assign m_raddr   = oc_r[IDX_W-1:0];

  assign key_rd = srt_sel_r ? ids_b_rd : ids_a_rd;
  assign srt_n  = srt_sel_r ? cnt_b_r : cnt_a_r;
  assign fm_i   = fm_sel_r ? pb_r : pa_r;
  assign fm_n1  = fm_sel_r ? cnt_b_r : cnt_a_r;
  assign a_lt_b = sa_rd < sb_rd;
  assign a_gt_b = sa_rd > sb_rd;

  assign ids_a_we = (st_r == ST_IDLE) && start && (in_command == CMD_LOAD_A)
                    && (cnt_a_r < CNT_MAX);
  assign ids_b_we = (st_r == ST_IDLE) && start && (in_command == CMD_LOAD_B)
                    && (cnt_b_r < CNT_MAX);
  assign srt_a_we = (st_r == ST_SRT_WR) && !srt_sel_r;
  assign srt_b_we = (st_r == ST_SRT_WR) && srt_sel_r;

  always_comb begin
    st_nxt       = st_r;
    phase_nxt    = phase_r;
    mode_nxt     = mode_r;
    drop_nxt     = drop_r;
    cnt_a_nxt    = cnt_a_r;
    cnt_b_nxt    = cnt_b_r;
    srt_sel_nxt  = srt_sel_r;
    k_nxt        = k_r;
    j_nxt        = j_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_idx_nxt  = cmp_idx_r;
    rank_nxt     = rank_r;
    key_nxt      = key_r;
    pa_nxt       = pa_r;
    pb_nxt       = pb_r;
    sc_nxt       = sc_r;
    fm_sel_nxt   = fm_sel_r;
    have_cur_nxt = have_cur_r;
    cur_f_nxt    = cur_f_r;
    cur_s_nxt    = cur_s_r;
    oc_nxt       = oc_r;
    osd_nxt      = osd_r;
    ov_nxt       = 1'b0;
    os_nxt       = os_r;
    of_nxt       = of_r;
    osec_nxt     = osec_r;
    ol_nxt       = ol_r;
    on_nxt       = on_r;
    oo_nxt       = oo_r;
    ma_we        = 1'b0;
    mb_we        = 1'b0;
    ma_waddr     = oa_rd;
    mb_waddr     = ob_rd;
    m_wdata      = NO_MATCH;
    fnd          = 1'b0;
    nfnd         = 1'b0;
    fnd_f        = oa_rd;
    fnd_s        = ob_rd;

    if (cfg_wr_en) begin
      mode_nxt  = cfg_wr_data;
      phase_nxt = PH_LOAD;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (start) begin
          case (in_command)
            CMD_CLEAR: begin
              cnt_a_nxt = '0;
              cnt_b_nxt = '0;
              drop_nxt  = 1'b0;
              phase_nxt = PH_LOAD;
            end
            CMD_LOAD_A: begin
              phase_nxt = PH_LOAD;
              if (cnt_a_r < CNT_MAX) cnt_a_nxt = cnt_a_r + 1'b1;
              else drop_nxt = 1'b1;
            end
            CMD_LOAD_B: begin
              phase_nxt = PH_LOAD;
              if (cnt_b_r < CNT_MAX) cnt_b_nxt = cnt_b_r + 1'b1;
              else drop_nxt = 1'b1;
            end
            default: begin
              if (phase_r == PH_LOAD) begin
                srt_sel_nxt = 1'b0;
                k_nxt       = '0;
                st_nxt      = ST_SRT_NEXT;
              end else if (phase_r == PH_EMIT) begin
                st_nxt = mode_r ? ST_O_RD : ST_ADV;
              end else begin
                ov_nxt   = 1'b1;
                os_nxt   = 1'b0;
                of_nxt   = '0;
                osec_nxt = '0;
                ol_nxt   = 1'b0;
                on_nxt   = 1'b1;
                oo_nxt   = drop_r;
              end
            end
          endcase
        end
      end
      ST_SRT_NEXT: begin
        if (k_r < srt_n) begin
          st_nxt = ST_SRT_KEY;
        end else if (!srt_sel_r) begin
          srt_sel_nxt = 1'b1;
          k_nxt       = '0;
        end else begin
          pa_nxt       = '0;
          pb_nxt       = '0;
          sc_nxt       = '0;
          have_cur_nxt = 1'b0;
          fm_sel_nxt   = 1'b0;
          st_nxt       = mode_r ? ST_FM_CHK : ST_SEEK;
        end
      end
      ST_SRT_KEY: st_nxt = ST_SRT_KEYW;
      ST_SRT_KEYW: begin
        key_nxt     = key_rd;
        j_nxt       = '0;
        cmp_vld_nxt = 1'b0;
        rank_nxt    = '0;
        st_nxt      = ST_SRT_SWP;
      end
      ST_SRT_SWP: begin
        // rank = entries that sort ahead of the key (smaller, or equal and loaded earlier)
        if (cmp_vld_r && ((key_rd < key_r) ||
                          ((key_rd == key_r) && (cmp_idx_r < k_r[IDX_W-1:0])))) begin
          rank_nxt = rank_r + 1'b1;
        end
        if (j_r < srt_n) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = j_r[IDX_W-1:0];
          j_nxt       = j_r + 1'b1;
        end else begin
          cmp_vld_nxt = 1'b0;
          if (!cmp_vld_r) st_nxt = ST_SRT_WR;
        end
      end
      ST_SRT_WR: begin
        k_nxt  = k_r + 1'b1;
        st_nxt = ST_SRT_NEXT;
      end
      ST_FM_CHK: begin
        if (fm_i < fm_n1) begin
          st_nxt = ST_FM_CMP;
        end else if (!fm_sel_r) begin
          fm_sel_nxt = 1'b1;
          pa_nxt     = '0;
          pb_nxt     = '0;
        end else begin
          oc_nxt  = '0;
          osd_nxt = (cnt_a_r == '0);
          if ((cnt_a_r != '0) || (cnt_b_r != '0)) begin
            phase_nxt = PH_EMIT;
            st_nxt    = ST_O_RD;
          end else begin
            phase_nxt = PH_DONE;
            ov_nxt    = 1'b1;
            os_nxt    = 1'b0;
            of_nxt    = '0;
            osec_nxt  = '0;
            ol_nxt    = 1'b0;
            on_nxt    = 1'b1;
            oo_nxt    = drop_r;
            st_nxt    = ST_IDLE;
          end
        end
      end
      ST_FM_CMP: begin
        st_nxt = ST_FM_CHK;
        if (!fm_sel_r) begin
          if ((pb_r >= cnt_b_r) || a_lt_b) begin
            ma_we  = 1'b1;
            pa_nxt = pa_r + 1'b1;
          end else if (a_gt_b) begin
            pb_nxt = pb_r + 1'b1;
          end else begin
            ma_we   = 1'b1;
            m_wdata = mat_t'({1'b0, ob_rd});
            pa_nxt  = pa_r + 1'b1;
          end
        end else begin
          if ((pa_r >= cnt_a_r) || a_gt_b) begin
            mb_we  = 1'b1;
            pb_nxt = pb_r + 1'b1;
          end else if (a_lt_b) begin
            pa_nxt = pa_r + 1'b1;
          end else begin
            mb_we   = 1'b1;
            m_wdata = mat_t'({1'b0, oa_rd});
            pb_nxt  = pb_r + 1'b1;
          end
        end
      end
      ST_O_RD: st_nxt = ST_O_EMIT;
      ST_O_EMIT: begin
        ov_nxt   = 1'b1;
        os_nxt   = osd_r;
        of_nxt   = oc_r[IDX_W-1:0];
        osec_nxt = osd_r ? mb_rd : ma_rd;
        on_nxt   = 1'b0;
        oo_nxt   = drop_r;
        ol_nxt   = 1'b0;
        st_nxt   = ST_IDLE;
        if (!osd_r) begin
          if (oc_r + 1'b1 >= cnt_a_r) begin
            osd_nxt = 1'b1;
            oc_nxt  = '0;
            if (cnt_b_r == '0) begin
              ol_nxt    = 1'b1;
              phase_nxt = PH_DONE;
            end
          end else begin
            oc_nxt = oc_r + 1'b1;
          end
        end else begin
          oc_nxt = oc_r + 1'b1;
          if (oc_r + 1'b1 >= cnt_b_r) begin
            ol_nxt    = 1'b1;
            phase_nxt = PH_DONE;
          end
        end
      end
      ST_SEEK: begin
        if ((pa_r < cnt_a_r) && (pb_r < cnt_b_r)) st_nxt = ST_SEEK_CMP;
        else nfnd = 1'b1;
      end
      ST_SEEK_CMP: begin
        if (a_lt_b) begin
          pa_nxt = pa_r + 1'b1;
          st_nxt = ST_SEEK;
        end else if (a_gt_b) begin
          pb_nxt = pb_r + 1'b1;
          st_nxt = ST_SEEK;
        end else begin
          sc_nxt = pb_r;
          fnd    = 1'b1;
        end
      end
      ST_ADV: begin
        sc_nxt = sc_r + 1'b1;
        st_nxt = ST_ADV_CHK;
      end
      ST_ADV_CHK: begin
        if (sc_r < cnt_b_r) begin
          st_nxt = ST_ADV_CMP;
        end else begin
          pa_nxt = pa_r + 1'b1;
          st_nxt = ST_SEEK;
        end
      end
      ST_ADV_CMP: begin
        if (!a_lt_b && !a_gt_b) begin
          fnd = 1'b1;
        end else begin
          pa_nxt = pa_r + 1'b1;
          st_nxt = ST_SEEK;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase

    // inner join: emit the held pair once the following one is known
    if (fnd) begin
      cur_f_nxt = fnd_f;
      cur_s_nxt = fnd_s;
      if (have_cur_r) begin
        ov_nxt    = 1'b1;
        os_nxt    = 1'b0;
        of_nxt    = cur_f_r;
        osec_nxt  = mat_t'({1'b0, cur_s_r});
        ol_nxt    = 1'b0;
        on_nxt    = 1'b0;
        oo_nxt    = drop_r;
        phase_nxt = PH_EMIT;
        st_nxt    = ST_IDLE;
      end else begin
        have_cur_nxt = 1'b1;
        st_nxt       = ST_ADV;
      end
    end
    if (nfnd) begin
      ov_nxt    = 1'b1;
      os_nxt    = 1'b0;
      of_nxt    = have_cur_r ? cur_f_r : '0;
      osec_nxt  = have_cur_r ? mat_t'({1'b0, cur_s_r}) : '0;
      ol_nxt    = have_cur_r;
      on_nxt    = !have_cur_r;
      oo_nxt    = drop_r;
      phase_nxt = PH_DONE;
      st_nxt    = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      phase_r   <= PH_LOAD;
      mode_r    <= 1'b0;
      drop_r    <= 1'b0;
      cnt_a_r   <= '0;
      cnt_b_r   <= '0;
      ov_r      <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      phase_r   <= phase_nxt;
      mode_r    <= mode_nxt;
      drop_r    <= drop_nxt;
      cnt_a_r   <= cnt_a_nxt;
      cnt_b_r   <= cnt_b_nxt;
      ov_r      <= ov_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    srt_sel_r  <= srt_sel_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    rank_r     <= rank_nxt;
    key_r      <= key_nxt;
    pa_r       <= pa_nxt;
    pb_r       <= pb_nxt;
    sc_r       <= sc_nxt;
    fm_sel_r   <= fm_sel_nxt;
    have_cur_r <= have_cur_nxt;
    cur_f_r    <= cur_f_nxt;
    cur_s_r    <= cur_s_nxt;
    oc_r       <= oc_nxt;
    osd_r      <= osd_nxt;
    os_r       <= os_nxt;
    of_r       <= of_nxt;
    osec_r     <= osec_nxt;
    ol_r       <= ol_nxt;
    on_r       <= on_nxt;
    oo_r       <= oo_nxt;
  end

  assign busy             = (st_r != ST_IDLE);
  assign out_valid        = ov_r;
  assign out_side         = os_r;
  assign out_first_index  = of_r;
  assign out_second_index = osec_r;
  assign out_last_result  = ol_r;
  assign out_nothing_left = on_r;
  assign out_overflowed   = oo_r;

  // loaded IDs, in load order
  smj_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTRIES)) u_ids_a (
    .clk(clk), .we(ids_a_we), .waddr(cnt_a_r[IDX_W-1:0]), .wdata(in_id_value),
    .raddr(ids_raddr), .rdata(ids_a_rd)
  );
  smj_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTRIES)) u_ids_b (
    .clk(clk), .we(ids_b_we), .waddr(cnt_b_r[IDX_W-1:0]), .wdata(in_id_value),
    .raddr(ids_raddr), .rdata(ids_b_rd)
  );

  // sorted IDs and their load positions
  smj_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTRIES)) u_sid_a (
    .clk(clk), .we(srt_a_we), .waddr(rank_r), .wdata(key_r),
    .raddr(a_raddr), .rdata(sa_rd)
  );
  smj_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTRIES)) u_sid_b (
    .clk(clk), .we(srt_b_we), .waddr(rank_r), .wdata(key_r),
    .raddr(b_raddr), .rdata(sb_rd)
  );
  smj_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_ord_a (
    .clk(clk), .we(srt_a_we), .waddr(rank_r), .wdata(k_r[IDX_W-1:0]),
    .raddr(a_raddr), .rdata(oa_rd)
  );
  smj_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_ord_b (
    .clk(clk), .we(srt_b_we), .waddr(rank_r), .wdata(k_r[IDX_W-1:0]),
    .raddr(b_raddr), .rdata(ob_rd)
  );

  // first-match tables for outer mode
  smj_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ENTRIES)) u_mat_a (
    .clk(clk), .we(ma_we), .waddr(ma_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(ma_rd)
  );
  smj_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ENTRIES)) u_mat_b (
    .clk(clk), .we(mb_we), .waddr(mb_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(mb_rd)
  );

endmodule
